// ===== hw/rtl/jacobi_five_point_stencil_assert.svh =====
// Assertion macros for the five-point stencil block.
`ifndef JACOBI_FIVE_POINT_STENCIL_ASSERT_SVH
`define JACOBI_FIVE_POINT_STENCIL_ASSERT_SVH

`ifndef SYNTHESIS
`define JFPS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("stencil assertion failed");
`define JFPS_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("stencil assertion failed");
`else
`define JFPS_ASSERT(label, clk, rst, prop)
`define JFPS_ASSERT_NEXT(label, clk, rst, pre, post)
`endif

`endif

// ===== hw/rtl/jfps_pkg.sv =====
// Shared constants, types and helpers of the five-point stencil block.
package jfps_pkg;

  localparam int DEF_MAX_COLS = 64;
  localparam int DEF_MAX_ROWS = 64;

  localparam int CELL_W  = 32;
  localparam int SUM_W   = 35;
  localparam int COORD_W = 6;
  localparam int FUNC_W  = 2;

  // config register widths and reset values
  localparam int ICOLS_W    = 6;
  localparam int IROWS_W    = 6;
  localparam int PAD_W      = 5;
  localparam int NPASS_W    = 4;
  localparam int RST_ICOLS  = 16;
  localparam int RST_IROWS  = 16;
  localparam int RST_PAD    = 1;
  localparam int RST_NPASS  = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  // divide by five, one 4-bit digit per step, magnitude first
  localparam int DIVISOR     = 5;
  localparam int DIGIT_W     = 4;
  localparam int DIV_DIGITS  = (SUM_W + DIGIT_W) / DIGIT_W;
  localparam int MAG_W       = DIV_DIGITS * DIGIT_W;
  localparam int REM_W       = $clog2(DIVISOR);
  localparam int V_W         = REM_W + DIGIT_W;
  localparam int RECIP_SHIFT = 10;
  localparam int RECIP       = (2 ** RECIP_SHIFT + DIVISOR - 1) / DIVISOR;
  localparam int CNT_W       = $clog2(DIV_DIGITS + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ICOLS,
    REG_IROWS,
    REG_PAD,
    REG_NPASS
  } cfg_reg_t;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD,
    FUNC_COMPUTE,
    FUNC_READ,
    FUNC_NOP
  } func_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // quotient digit of a partial remainder below 16*DIVISOR, by reciprocal
  function automatic logic [DIGIT_W-1:0] div5_digit(input logic [V_W-1:0] v);
    logic [V_W+RECIP_SHIFT-1:0] p;
    p = (V_W + RECIP_SHIFT)'(v) * (V_W + RECIP_SHIFT)'(RECIP);
    return p[RECIP_SHIFT +: DIGIT_W];
  endfunction

endpackage

// ===== hw/rtl/jfps_ram.sv =====
// Simple dual-port cell buffer: one write port, one registered read port.
module jfps_ram import jfps_pkg::*; #(
  parameter int DEPTH = DEF_MAX_ROWS * DEF_MAX_COLS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [CELL_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/jfps_div5.sv =====
// Iterative signed divide by five, truncating toward zero, one digit per cycle.
module jfps_div5 import jfps_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] sum,
  output div_stat_t               stat,
  output logic [CELL_W-1:0]       quo
);

  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  cnt;
  logic              neg;
  logic [MAG_W-1:0]  mag;
  logic [MAG_W-1:0]  qacc;
  logic [REM_W-1:0]  rem;

  logic signed [MAG_W-1:0] sx;
  logic [DIGIT_W-1:0]      digit;
  logic [V_W-1:0]          v;
  logic [DIGIT_W-1:0]      qd;
  logic [V_W-1:0]          prod;
  logic [REM_W-1:0]        rem_next;
  logic [MAG_W-1:0]        qfin;

  always_comb begin
    sx       = MAG_W'(sum);
    digit    = mag[MAG_W-1 -: DIGIT_W];
    v        = {rem, digit};
    qd       = div5_digit(v);
    prod     = V_W'(qd) * V_W'(DIVISOR);
    rem_next = REM_W'(v - prod);
    qfin     = {qacc[MAG_W-DIGIT_W-1:0], qd};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_DIGITS);
        neg  <= sum[SUM_W-1];
        mag  <= sum[SUM_W-1] ? -sx : sx;
        rem  <= '0;
        qacc <= '0;
      end else if (busy) begin
        mag  <= mag << DIGIT_W;
        rem  <= rem_next;
        qacc <= qfin;
        cnt  <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
          quo  <= neg ? -qfin[CELL_W-1:0] : qfin[CELL_W-1:0];
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== hw/rtl/jacobi_five_point_stencil.sv =====
// Jacobi five-point stencil over a padded 2D grid held in two ping-pong buffers.
//
// Every transaction gives exactly one result. Loads (and unknown codes) stream at one
// per cycle while m_axis_tready stays high; a read passes through ST_RDOUT because
// of the registered buffer read. A compute runs npass sweeps over the whole
// MAX_ROWS x MAX_COLS store: a cell that is updated takes five reads through the
// single read port of the source buffer, one add, nine steps of the divide-by-five
// unit and one write; every other cell takes a read and a copy. The default store
// is 64 x 64 with a 16 x 16 interior. The input is not ready while a compute runs.
// The buffers are not cleared after reset; read only loaded cells.
`include "jacobi_five_point_stencil_assert.svh"

module jacobi_five_point_stencil import jfps_pkg::*; #(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [47:0]           s_axis_tdata,   // row[5:0], col[11:6], cell_in[43:12], zero
  input  logic [FUNC_W-1:0]     s_axis_tuser,   // func[1:0]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [CELL_W-1:0]     m_axis_tdata,   // cell_out[31:0]
  output logic [FUNC_W-1:0]     m_axis_tuser,   // func_done[1:0]
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int MW    = (RW > CW) ? RW : CW;
  localparam int XW    = ((MW > 7) ? MW : 7) + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDOUT,
    ST_TAP,
    ST_SUM,
    ST_DIV,
    ST_COPY
  } state_t;

  typedef enum logic [2:0] {
    TAP_CTR,
    TAP_UP,
    TAP_DN,
    TAP_LT,
    TAP_RT
  } tap_t;

  function automatic logic [AW-1:0] cell_idx(input logic [XW-1:0] r, input logic [XW-1:0] c);
    logic [AW+XW-1:0] p;
    p = (AW + XW)'(r) * (AW + XW)'(MAX_COLS) + (AW + XW)'(c);
    return p[AW-1:0];
  endfunction

  state_t               state;
  tap_t                 tap;
  logic [ICOLS_W-1:0]   icols;
  logic [IROWS_W-1:0]   irows;
  logic [PAD_W-1:0]     pad;
  logic [NPASS_W-1:0]   npass;
  logic [NPASS_W-1:0]   pass_left;
  logic [RW-1:0]        rr;
  logic [CW-1:0]        cc;
  logic                 newest_is_b;
  logic                 out_valid;
  logic [CELL_W-1:0]    out_data;
  logic [FUNC_W-1:0]    out_func;
  logic                 rd_ok;
  logic [SUM_W-1:0]     acc;

  logic                 s_fire;
  logic                 m_fire;
  func_t                s_func;
  logic [XW-1:0]        xrow, xcol, xr, xc, xp, prow, pcol, tr, tc;
  logic                 in_ok;
  logic                 inner;
  logic                 last_col, last_cell;
  logic [AW-1:0]        in_idx, cur_idx, tap_idx, raddr, waddr;
  logic [CELL_W-1:0]    wdata, rd_a, rd_b, src_rd;
  logic [SUM_W-1:0]     rd_ext, acc_base, add_sum;
  logic                 we_load, we_pass, we_a, we_b;
  logic                 div_start;
  div_stat_t            div_stat;
  logic [CELL_W-1:0]    div_quo;

  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign m_fire = m_axis_tvalid && m_axis_tready;
  assign s_func = func_t'(s_axis_tuser);

  assign s_axis_tready = (state == ST_IDLE) && (!out_valid || m_axis_tready);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_func;
  assign cfg_ready     = 1'b1;

  always_comb begin
    xrow  = XW'(s_axis_tdata[COORD_W-1:0]);
    xcol  = XW'(s_axis_tdata[2*COORD_W-1:COORD_W]);
    xp    = XW'(pad);
    prow  = XW'(irows) + (xp << 1);
    pcol  = XW'(icols) + (xp << 1);
    in_ok = (xrow < prow) && (xcol < pcol) &&
            (xrow < XW'(MAX_ROWS)) && (xcol < XW'(MAX_COLS));
    in_idx = cell_idx(xrow, xcol);

    xr = XW'(rr);
    xc = XW'(cc);
    // interior of the padded grid, with all four neighbours inside the store
    inner = (xr >= xp) && (xr < xp + XW'(irows)) &&
            (xc >= xp) && (xc < xp + XW'(icols)) &&
            (xr != '0) && (xc != '0) &&
            (xr + 1'b1 < XW'(MAX_ROWS)) && (xc + 1'b1 < XW'(MAX_COLS));

    case (tap)
      TAP_UP: begin
        tr = xr - 1'b1;
        tc = xc;
      end
      TAP_DN: begin
        tr = xr + 1'b1;
        tc = xc;
      end
      TAP_LT: begin
        tr = xr;
        tc = xc - 1'b1;
      end
      TAP_RT: begin
        tr = xr;
        tc = xc + 1'b1;
      end
      default: begin
        tr = xr;
        tc = xc;
      end
    endcase
    cur_idx = cell_idx(xr, xc);
    tap_idx = cell_idx(tr, tc);

    last_col  = (cc == CW'(MAX_COLS - 1));
    last_cell = last_col && (rr == RW'(MAX_ROWS - 1));

    src_rd   = newest_is_b ? rd_b : rd_a;
    rd_ext   = SUM_W'(signed'(src_rd));
    acc_base = (state == ST_TAP && tap == TAP_UP) ? '0 : acc;
    add_sum  = acc_base + rd_ext;

    div_start = (state == ST_SUM);
    we_load   = s_fire && (s_func == FUNC_LOAD) && in_ok;
    we_pass   = (state == ST_COPY) || (state == ST_DIV && div_stat.done);
    we_a      = we_load || (we_pass && newest_is_b);
    we_b      = we_load || (we_pass && !newest_is_b);

    raddr = (state == ST_IDLE) ? in_idx : tap_idx;
    waddr = (state == ST_IDLE) ? in_idx : cur_idx;
    if (state == ST_IDLE) begin
      wdata = s_axis_tdata[2*COORD_W +: CELL_W];
    end else if (state == ST_DIV) begin
      wdata = div_quo;
    end else begin
      wdata = src_rd;
    end
  end

  jfps_ram #(.DEPTH(DEPTH), .AW(AW)) u_grid_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_a)
  );

  jfps_ram #(.DEPTH(DEPTH), .AW(AW)) u_grid_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_b)
  );

  jfps_div5 u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .sum   (signed'(add_sum)),
    .stat  (div_stat),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      tap         <= TAP_CTR;
      icols       <= ICOLS_W'(RST_ICOLS);
      irows       <= IROWS_W'(RST_IROWS);
      pad         <= PAD_W'(RST_PAD);
      npass       <= NPASS_W'(RST_NPASS);
      pass_left   <= '0;
      rr          <= '0;
      cc          <= '0;
      newest_is_b <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_reg_t'(cfg_index))
          REG_ICOLS: icols <= cfg_data[ICOLS_W-1:0];
          REG_IROWS: irows <= cfg_data[IROWS_W-1:0];
          REG_PAD:   pad   <= cfg_data[PAD_W-1:0];
          REG_NPASS: npass <= cfg_data[NPASS_W-1:0];
          default: ;
        endcase
      end

      if (m_fire) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (s_fire) begin
            out_func <= s_axis_tuser;
            out_data <= '0;
            case (s_func)
              FUNC_COMPUTE: begin
                if (npass != '0) begin
                  state     <= ST_TAP;
                  tap       <= TAP_CTR;
                  pass_left <= npass;
                  rr        <= '0;
                  cc        <= '0;
                end else begin
                  out_valid <= 1'b1;
                end
              end
              FUNC_READ: begin
                rd_ok <= in_ok;
                state <= ST_RDOUT;
              end
              default: out_valid <= 1'b1;
            endcase
          end
        end
        ST_RDOUT: begin
          out_data  <= rd_ok ? src_rd : '0;
          out_valid <= 1'b1;
          state     <= ST_IDLE;
        end
        ST_TAP: begin
          // read for one tap is issued while the previous tap is summed
          if (tap == TAP_CTR) begin
            if (inner) begin
              tap <= TAP_UP;
            end else begin
              state <= ST_COPY;
            end
          end else begin
            acc <= add_sum;
            case (tap)
              TAP_UP:  tap   <= TAP_DN;
              TAP_DN:  tap   <= TAP_LT;
              TAP_LT:  tap   <= TAP_RT;
              default: state <= ST_SUM;
            endcase
          end
        end
        ST_SUM: state <= ST_DIV;
        ST_DIV: ;
        ST_COPY: ;
        default: state <= ST_IDLE;
      endcase

      // cell written: step to the next cell, pass or finish
      if (we_pass) begin
        tap   <= TAP_CTR;
        state <= ST_TAP;
        if (last_cell) begin
          rr          <= '0;
          cc          <= '0;
          newest_is_b <= !newest_is_b;
          if (pass_left == NPASS_W'(1)) begin
            state     <= ST_IDLE;
            out_valid <= 1'b1;
          end else begin
            pass_left <= pass_left - 1'b1;
          end
        end else if (last_col) begin
          cc <= '0;
          rr <= rr + 1'b1;
        end else begin
          cc <= cc + 1'b1;
        end
      end
    end
  end

  `JFPS_ASSERT(a_div_free, clk, rst, div_start |-> !div_stat.busy)
  `JFPS_ASSERT(a_done_wait, clk, rst, div_stat.done |-> (state == ST_DIV))
  `JFPS_ASSERT(a_dual_write, clk, rst, (we_a && we_b) |-> s_fire)
  `JFPS_ASSERT_NEXT(a_cmp_busy, clk, rst, s_fire && s_func == FUNC_COMPUTE && npass != '0, !s_axis_tready)

endmodule
